>>> rtl/core/assert_macros.svh
// Assertion helpers used by the pose transform datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/pfc_pkg.sv
package pfc_pkg;

	localparam int PosW    = 32;
	localparam int AngW    = 16;
	localparam int Stages  = 16;
	localparam int Guard   = 8;
	localparam int CordW   = PosW + Guard + 2;
	localparam int RotLat  = Stages + 5;
	localparam logic [31:0] GainQ32 = 32'h9B74EDA8;

	typedef enum logic [1:0] {
		CMD_FWD    = 2'd0,
		CMD_BWD    = 2'd1,
		CMD_DERIVE = 2'd2,
		CMD_UPDATE = 2'd3
	} cmd_t;

	typedef logic signed [PosW-1:0] pos_t;
	typedef logic [AngW-1:0]        ang_t;
	typedef logic signed [CordW-1:0] cord_t;

	typedef struct packed {
		cord_t       x;
		cord_t       y;
		logic signed [32:0] z;
	} cell_t;

	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] t [24];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		return t[i];
	endfunction

endpackage

>>> rtl/core/pfc_cell.sv
module pfc_cell (
	input  logic            clk,
	input  logic [4:0]      sh_amt,
	input  logic [31:0]     angle_step,
	input  pfc_pkg::cell_t  d,
	output pfc_pkg::cell_t  q
);
	logic signed [32:0] step_z;

	pfc_pkg::cord_t sx;
	pfc_pkg::cord_t sy;

	assign step_z = {1'b0, angle_step};
	assign sx = d.x >>> sh_amt;
	assign sy = d.y >>> sh_amt;

	always_ff @(posedge clk) begin
		if (!d.z[32]) begin
			q.x <= d.x - sy;
			q.y <= d.y + sx;
			q.z <= d.z - step_z;
		end else begin
			q.x <= d.x + sy;
			q.y <= d.y - sx;
			q.z <= d.z + step_z;
		end
	end
endmodule

>>> rtl/core/pfc_rotate.sv
module pfc_rotate (
	input  logic          clk,
	input  pfc_pkg::pos_t x,
	input  pfc_pkg::pos_t y,
	input  pfc_pkg::ang_t a,
	output pfc_pkg::pos_t rx,
	output pfc_pkg::pos_t ry
);
	localparam int W = pfc_pkg::CordW;

	pfc_pkg::cell_t chain [pfc_pkg::Stages+1];
	pfc_pkg::cell_t head_q;
	logic [31:0] t;
	logic [31:0] t2;
	logic        flip;
	pfc_pkg::cord_t xg;
	pfc_pkg::cord_t yg;

	assign t    = {a, {(32-pfc_pkg::AngW){1'b0}}};
	assign flip = t[31] ^ t[30];
	assign t2   = flip ? t + 32'h80000000 : t;
	assign xg   = W'(x) <<< pfc_pkg::Guard;
	assign yg   = W'(y) <<< pfc_pkg::Guard;

	always_ff @(posedge clk) begin
		head_q.x <= flip ? -xg : xg;
		head_q.y <= flip ? -yg : yg;
		head_q.z <= {t2[31], t2};
	end

	assign chain[0] = head_q;

	for (genvar i = 0; i < pfc_pkg::Stages; i++) begin : g_cell
		pfc_cell u_cell (
			.clk(clk),
			.sh_amt(5'(i)),
			.angle_step(pfc_pkg::atan_turns(i)),
			.d(chain[i]),
			.q(chain[i+1])
		);
	end

	logic        negx_s1, negy_s1;
	logic [W-1:0] mx_s1, my_s1;
	logic [63:0] plx_s2, ply_s2;
	logic [W-1:0] phx_s2, phy_s2;
	logic        negx_s2, negy_s2;
	logic [W-1:0] mgx_s3, mgy_s3;
	logic        negx_s3, negy_s3;
	logic signed [W:0] gx_s4, gy_s4;
	logic signed [W:0] rndx, rndy;

	always_ff @(posedge clk) begin
		negx_s1 <= chain[pfc_pkg::Stages].x[W-1];
		negy_s1 <= chain[pfc_pkg::Stages].y[W-1];
		mx_s1 <= chain[pfc_pkg::Stages].x[W-1] ? -chain[pfc_pkg::Stages].x
		                                        : chain[pfc_pkg::Stages].x;
		my_s1 <= chain[pfc_pkg::Stages].y[W-1] ? -chain[pfc_pkg::Stages].y
		                                        : chain[pfc_pkg::Stages].y;
		plx_s2 <= 64'(mx_s1[31:0]) * 64'(pfc_pkg::GainQ32);
		ply_s2 <= 64'(my_s1[31:0]) * 64'(pfc_pkg::GainQ32);
		phx_s2 <= W'(mx_s1[W-1:32]) * W'(pfc_pkg::GainQ32);
		phy_s2 <= W'(my_s1[W-1:32]) * W'(pfc_pkg::GainQ32);
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
		mgx_s3 <= phx_s2 + W'((plx_s2 + 64'h80000000) >> 32);
		mgy_s3 <= phy_s2 + W'((ply_s2 + 64'h80000000) >> 32);
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		gx_s4 <= negx_s3 ? -$signed({1'b0, mgx_s3}) : $signed({1'b0, mgx_s3});
		gy_s4 <= negy_s3 ? -$signed({1'b0, mgy_s3}) : $signed({1'b0, mgy_s3});
	end

	assign rndx = gx_s4 + (W+1)'(1 << (pfc_pkg::Guard-1));
	assign rndy = gy_s4 + (W+1)'(1 << (pfc_pkg::Guard-1));

	always_ff @(posedge clk) begin
		rx <= rndx[pfc_pkg::Guard +: pfc_pkg::PosW];
		ry <= rndy[pfc_pkg::Guard +: pfc_pkg::PosW];
	end
endmodule

>>> rtl/core/pose_frame_correction.sv
// Pose transform pipeline for the four planar transforms selected by cmd. busy is tied low,
// so a request is accepted at every rising edge with start high, back to back if needed.
// Each result leaves in request order on out_x, out_y and out_angle for one cycle with done
// high. Its path is two CORDIC rotators in series, each an input stage, 16 cells, four gain
// multiply and rounding stages and an output register, plus one combining stage between them
// and the final output register. The receiver cannot stall, so take the result in that cycle.
`include "assert_macros.svh"
module pose_frame_correction (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       cmd,
	input  logic signed [pfc_pkg::PosW-1:0]  first_x,
	input  logic signed [pfc_pkg::PosW-1:0]  first_y,
	input  logic signed [pfc_pkg::AngW-1:0]  first_angle,
	input  logic signed [pfc_pkg::PosW-1:0]  second_x,
	input  logic signed [pfc_pkg::PosW-1:0]  second_y,
	input  logic signed [pfc_pkg::AngW-1:0]  second_angle,
	input  logic signed [pfc_pkg::PosW-1:0]  delta_x,
	input  logic signed [pfc_pkg::PosW-1:0]  delta_y,
	input  logic signed [pfc_pkg::AngW-1:0]  delta_angle,
	output logic                             done,
	output logic signed [pfc_pkg::PosW-1:0]  out_x,
	output logic signed [pfc_pkg::PosW-1:0]  out_y,
	output logic signed [pfc_pkg::AngW-1:0]  out_angle
);
	localparam int L  = pfc_pkg::RotLat;
	localparam int LT = 2 * L + 3;

	typedef struct packed {
		logic [1:0]    cmd;
		pfc_pkg::pos_t x1, y1, x2, y2, dx, dy;
		pfc_pkg::ang_t a1, a2, da;
	} req_t;

	req_t d_q [L+1];
	logic [LT:0] vld_q;

	pfc_pkg::pos_t r1x, r1y, r2x, r2y;
	pfc_pkg::pos_t in1x, in1y;
	pfc_pkg::ang_t in1a;
	req_t cur;

	assign busy = 1'b0;

	always_comb begin
		in1x = first_x;
		in1y = first_y;
		in1a = second_angle;
		case (pfc_pkg::cmd_t'(cmd))
			pfc_pkg::CMD_FWD: begin
				in1x = first_x - second_x;
				in1y = first_y - second_y;
				in1a = -second_angle;
			end
			pfc_pkg::CMD_DERIVE: begin
				in1x = second_x;
				in1y = second_y;
				in1a = first_angle - second_angle;
			end
			default: ;
		endcase
	end

	pfc_rotate u_rot1 (.clk(clk), .x(in1x), .y(in1y), .a(in1a), .rx(r1x), .ry(r1y));

	always_ff @(posedge clk) begin
		d_q[0] <= '{cmd, first_x, first_y, second_x, second_y, delta_x, delta_y,
		            first_angle, second_angle, delta_angle};
		for (int i = 1; i <= L; i++) d_q[i] <= d_q[i-1];
	end

	assign cur = d_q[L];

	// stage after rotator one: form result or second rotate request
	pfc_pkg::pos_t px, py, cx, cy;
	pfc_pkg::ang_t pa, oa2;
	pfc_pkg::pos_t a_x_s1, a_y_s1;
	pfc_pkg::ang_t a_a_s1;
	logic [1:0]    a_cmd_s1;

	assign px  = cur.x2 + r1x;
	assign py  = cur.y2 + r1y;
	assign pa  = cur.a2 + cur.a1;
	assign cx  = cur.x1 + cur.dx;
	assign cy  = cur.y1 + cur.dy;
	assign oa2 = pa - (cur.a1 + cur.da);

	always_ff @(posedge clk) begin
		a_cmd_s1 <= cur.cmd;
		case (pfc_pkg::cmd_t'(cur.cmd))
			pfc_pkg::CMD_FWD: begin
				a_x_s1 <= r1x; a_y_s1 <= r1y; a_a_s1 <= cur.a1 - cur.a2;
			end
			pfc_pkg::CMD_BWD: begin
				a_x_s1 <= px; a_y_s1 <= py; a_a_s1 <= pa;
			end
			pfc_pkg::CMD_DERIVE: begin
				a_x_s1 <= cur.x1 - r1x; a_y_s1 <= cur.y1 - r1y;
				a_a_s1 <= cur.a1 - cur.a2;
			end
			default: begin
				a_x_s1 <= px; a_y_s1 <= py; a_a_s1 <= oa2;
			end
		endcase
	end

	pfc_pkg::pos_t cx_s1, cy_s1;
	always_ff @(posedge clk) begin
		cx_s1 <= cx;
		cy_s1 <= cy;
	end

	pfc_rotate u_rot2 (.clk(clk), .x(cx_s1), .y(cy_s1), .a(a_a_s1), .rx(r2x), .ry(r2y));

	typedef struct packed {
		logic [1:0]    cmd;
		pfc_pkg::pos_t x, y;
		pfc_pkg::ang_t a;
	} res_t;

	res_t b_q [L+1];
	always_ff @(posedge clk) begin
		b_q[0] <= '{a_cmd_s1, a_x_s1, a_y_s1, a_a_s1};
		for (int i = 1; i <= L; i++) b_q[i] <= b_q[i-1];
	end

	always_ff @(posedge clk) begin
		out_angle <= b_q[L].a;
		if (b_q[L].cmd == pfc_pkg::CMD_UPDATE) begin
			out_x <= b_q[L].x - r2x;
			out_y <= b_q[L].y - r2y;
		end else begin
			out_x <= b_q[L].x;
			out_y <= b_q[L].y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LT-1:0], start};
		end
	end

	assign done = vld_q[LT];

	`ASSERT_IMPLIES(a_never_busy, clk, arst_n, 1'b1, !busy)
	`ASSERT_NEXT(a_done_follows, clk, arst_n, vld_q[LT-1], done)
	`ASSERT_NEXT(a_no_spurious, clk, arst_n, !vld_q[LT-1], !done)
endmodule

>>> verif/tb_top.sv
module tb_top;

	localparam int LATENCY = 2 * pfc_pkg::RotLat + 3;
	localparam longint LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = '0;
	logic signed [31:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic signed [31:0] delta_x = '0, delta_y = '0;
	logic signed [15:0] first_angle = '0, second_angle = '0, delta_angle = '0;
	logic done;
	logic signed [31:0] out_x, out_y;
	logic signed [15:0] out_angle;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0] a;
	} pose_s;

	pose_s expected_poses[$];
	int errors = 0;
	longint cycles = 0;

	pose_frame_correction dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	localparam logic [31:0] ATAN_TBL [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint scale_gain(longint v);
		logic [63:0] m, lo, hi, r;
		m = (v < 0) ? -v : v;
		lo = m & 64'hFFFFFFFF;
		hi = m >> 32;
		r = hi * 64'h9B74EDA8 + ((lo * 64'h9B74EDA8 + 64'h80000000) >> 32);
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	task automatic spin(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [15:0] a, output logic signed [31:0] rx,
			output logic signed [31:0] ry);
		logic [31:0] t;
		longint vx, vy, z, sx, sy;
		t = {a, 16'h0};
		vx = longint'(x) * 256;
		vy = longint'(y) * 256;
		if (t[31:30] == 2'd1 || t[31:30] == 2'd2) begin
			vx = -vx;
			vy = -vy;
			t = t + 32'h80000000;
		end
		z = longint'(signed'(t));
		for (int i = 0; i < pfc_pkg::Stages && i < 24; i++) begin
			sx = floor_shr(vx, i);
			sy = floor_shr(vy, i);
			if (z >= 0) begin
				vx = vx - sy;
				vy = vy + sx;
				z = z - longint'(ATAN_TBL[i]);
			end else begin
				vx = vx + sy;
				vy = vy - sx;
				z = z + longint'(ATAN_TBL[i]);
			end
		end
		vx = scale_gain(vx);
		vy = scale_gain(vy);
		rx = 32'(floor_shr(vx + 128, 8));
		ry = 32'(floor_shr(vy + 128, 8));
	endtask

	task automatic apply_corr(input pose_s p, input pose_s c, output pose_s o);
		logic signed [31:0] rx, ry;
		spin(p.x, p.y, c.a, rx, ry);
		o.a = c.a + p.a;
		o.x = c.x + rx;
		o.y = c.y + ry;
	endtask

	task automatic derive_corr(input pose_s p, input pose_s q, output pose_s o);
		logic signed [31:0] rx, ry;
		o.a = p.a - q.a;
		spin(q.x, q.y, o.a, rx, ry);
		o.x = p.x - rx;
		o.y = p.y - ry;
	endtask

	task automatic predict_pose(input pfc_pkg::cmd_t c, input pose_s p1, input pose_s p2,
			input pose_s d, output pose_s o);
		pose_s q, m;
		case (c)
			pfc_pkg::CMD_FWD: begin
				o.a = p1.a - p2.a;
				spin(p1.x - p2.x, p1.y - p2.y, -p2.a, o.x, o.y);
			end
			pfc_pkg::CMD_BWD: apply_corr(p1, p2, o);
			pfc_pkg::CMD_DERIVE: derive_corr(p1, p2, o);
			default: begin
				apply_corr(p1, p2, q);
				m.x = p1.x + d.x;
				m.y = p1.y + d.y;
				m.a = p1.a + d.a;
				derive_corr(q, m, o);
			end
		endcase
	endtask

	// drive at a falling edge; return at the falling edge after the accepting edge
	task automatic send_request(input pfc_pkg::cmd_t c, input pose_s p1, input pose_s p2,
			input pose_s d);
		pose_s o;
		start <= 1'b1;
		cmd <= c;
		first_x <= p1.x; first_y <= p1.y; first_angle <= p1.a;
		second_x <= p2.x; second_y <= p2.y; second_angle <= p2.a;
		delta_x <= d.x; delta_y <= d.y; delta_angle <= d.a;
		do @(posedge clk); while (busy);
		predict_pose(c, p1, p2, d, o);
		expected_poses.push_back(o);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic pose_s rand_pose(int mode);
		pose_s p;
		case (mode)
			0: begin
				p.x = $urandom; p.y = $urandom; p.a = 16'($urandom);
			end
			1: begin
				p.x = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
				p.y = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
				p.a = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			end
			default: begin
				p.x = 32'(int'($urandom_range(0, 200000)) - 100000);
				p.y = 32'(int'($urandom_range(0, 200000)) - 100000);
				p.a = 16'($urandom);
			end
		endcase
		return p;
	endfunction

	task automatic test_directed();
		pose_s z, p, q;
		z = '{0, 0, 0};
		for (int c = 0; c < 4; c++) begin
			send_request(pfc_pkg::cmd_t'(c), z, z, z);
			p = '{32'h7FFFFFFF, 32'h80000000, 16'h8000};
			q = '{32'h80000000, 32'h7FFFFFFF, 16'h7FFF};
			send_request(pfc_pkg::cmd_t'(c), p, q, p);
			send_request(pfc_pkg::cmd_t'(c), q, p, q);
			p = '{32'h00000100, 32'h00000200, 16'h4000};
			q = '{32'h00000300, 32'hFFFFFF00, 16'h8000};
			send_request(pfc_pkg::cmd_t'(c), p, q, '{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF});
			send_request(pfc_pkg::cmd_t'(c), p, '{0, 0, 16'hC000}, z);
		end
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			pause($urandom_range(0, 17));
			send_request(pfc_pkg::cmd_t'($urandom_range(0, 3)),
				rand_pose($urandom_range(0, 5)), rand_pose($urandom_range(0, 5)),
				rand_pose($urandom_range(0, 5)));
		end
	endtask

	task automatic test_back_to_back(int n);
		for (int i = 0; i < n; i++)
			send_request(pfc_pkg::cmd_t'($urandom_range(0, 3)), rand_pose(0), rand_pose(2),
				rand_pose(0));
	endtask

	task automatic drain();
		start <= 1'b0;
		wait (expected_poses.size() == 0);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		pose_s e;
		if (arst_n && done) begin
			if (expected_poses.size() == 0) begin
				$error("unexpected result x=%0d y=%0d a=%0d", out_x, out_y, out_angle);
				errors++;
			end else begin
				e = expected_poses.pop_front();
				if (out_x !== e.x) begin
					$error("out_x expected %0d actual %0d", e.x, out_x);
					errors++;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %0d actual %0d", e.y, out_y);
					errors++;
				end
				if (out_angle !== e.a) begin
					$error("out_angle expected %0d actual %0d", e.a, out_angle);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		drain();
		test_random(300);
		drain();
		test_back_to_back(200);
		test_random(100);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_poses.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pfc_pkg.sv
rtl/core/pfc_cell.sv
rtl/core/pfc_rotate.sv
rtl/core/pose_frame_correction.sv
verif/tb_top.sv
